>>> src/ilap_pkg.sv
`default_nettype none
// ============================================================================
// ilap_pkg: shared types and constants for the IMU lever-arm predictor
// Sample and lane widths, queue depth, pipeline latencies, the configuration
// register map and the item formats passed between the front and back ends.
// ============================================================================
package ilap_pkg;

    localparam int SMP_W       = 24;          // Q12.12 sample lane
    localparam int LANE_W      = 16;          // lever arm, quaternion and bias lanes
    localparam int QUAT_W      = 4 * LANE_W;
    localparam int ARM_W       = 3 * LANE_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MODE_W      = 2;
    localparam int MODE_BIAS_BIT = 0;
    localparam int MODE_BASE_BIT = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int LEVER_LAT   = 4;
    localparam int ROT_LAT     = 4;

    localparam int LEV_FRAC    = 12;          // fraction bits of the lever arm
    localparam int ROT_T_SHIFT = 13;          // rounding of t = 2 (qv x v)
    localparam int ROT_SHIFT   = 14;          // fraction bits of the quaternion
    localparam int ROT_GROW    = 8;           // growth of a rotated value
    localparam int BIAS_SHIFT  = 4;           // Q8.8 to Q12.12

    // Width of the acceleration at the IMU position, before rotation.
    localparam int ACC_ROT_W   = SMP_W + LANE_W + 2;
    localparam int RATE_ROT_W  = SMP_W;

    localparam logic [QUAT_W-1:0] QUAT_RESET = QUAT_W'(16384);

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W - 1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W - 1){1'b0}}};

    // Operand lanes of a cross product: o[i] = a[CJ[i]] * b[CK[i]] - a[CK[i]] * b[CJ[i]].
    localparam int CJ [3] = '{1, 2, 0};
    localparam int CK [3] = '{2, 0, 1};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_MODE = 3'd0,
        REG_LEVER_ARM  = 3'd1,
        REG_MOUNT_QUAT = 3'd2,
        REG_ACCEL_BIAS = 3'd3,
        REG_GYRO_BIAS  = 3'd4
    } cfg_reg_t;

    typedef logic [2:0][SMP_W-1:0]  vec3_t;
    typedef logic [2:0][LANE_W-1:0] lane3_t;

    // A queued sample with its processing class.
    typedef struct packed {
        logic  base;
        logic  bias;
        vec3_t acc;
        vec3_t rate;
        vec3_t alpha;
    } item_t;

    // What travels alongside the arithmetic down the back end.
    typedef struct packed {
        logic  base;
        logic  bias;
        vec3_t acc;
        vec3_t rate;
    } side_t;

endpackage
`default_nettype wire

>>> src/ilap_if.sv
`default_nettype none
// ============================================================================
// ilap_if: valid/ready channels of the IMU lever-arm predictor
// ilap_in_if carries one body kinematic sample per beat, ilap_out_if one
// predicted IMU reading per beat.
// ============================================================================
interface ilap_in_if
    import ilap_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  acc_x;
    logic [SMP_W-1:0]  acc_y;
    logic [SMP_W-1:0]  acc_z;
    logic [SMP_W-1:0]  rate_x;
    logic [SMP_W-1:0]  rate_y;
    logic [SMP_W-1:0]  rate_z;
    logic [SMP_W-1:0]  ang_acc_x;
    logic [SMP_W-1:0]  ang_acc_y;
    logic [SMP_W-1:0]  ang_acc_z;

    modport source (
        output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
               ang_acc_x, ang_acc_y, ang_acc_z,
        input  ready
    );
    modport sink (
        input  valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
               ang_acc_x, ang_acc_y, ang_acc_z,
        output ready
    );
endinterface

interface ilap_out_if
    import ilap_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  pred_acc_x;
    logic [SMP_W-1:0]  pred_acc_y;
    logic [SMP_W-1:0]  pred_acc_z;
    logic [SMP_W-1:0]  pred_rate_x;
    logic [SMP_W-1:0]  pred_rate_y;
    logic [SMP_W-1:0]  pred_rate_z;
    logic              saturated;

    modport source (
        output valid, pred_acc_x, pred_acc_y, pred_acc_z,
               pred_rate_x, pred_rate_y, pred_rate_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, pred_acc_x, pred_acc_y, pred_acc_z,
               pred_rate_x, pred_rate_y, pred_rate_z, saturated,
        output ready
    );
endinterface
`default_nettype wire

>>> src/ilap_front.sv
`default_nettype none
// ============================================================================
// ilap_front: sample intake and queue
// Accepts sample beats, tags each with its processing class from the frame
// mode, and holds them in a small queue that the back end drains.
// ============================================================================
module ilap_front
    import ilap_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic                clk,
    input  logic                rst_n,
    ilap_in_if.sink             sample,
    input  logic [MODE_W-1:0]   frame_mode,
    input  logic                pop,
    output logic                head_valid,
    output item_t               head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              q_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               take;
    item_t              item_in;

    assign sample.ready = (count_reg != CNT_W'(DEPTH));
    assign push         = sample.valid && sample.ready;
    assign head_valid   = (count_reg != '0);
    assign take         = pop && head_valid;
    assign head         = q_mem[rd_ptr_reg];

    always_comb
    begin
        item_in.base  = frame_mode[MODE_BASE_BIT];
        item_in.bias  = frame_mode[MODE_BIAS_BIT];
        item_in.acc   = {sample.acc_z, sample.acc_y, sample.acc_x};
        item_in.rate  = {sample.rate_z, sample.rate_y, sample.rate_x};
        item_in.alpha = {sample.ang_acc_z, sample.ang_acc_y, sample.ang_acc_x};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (take && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/ilap_lever.sv
`default_nettype none
// ============================================================================
// ilap_lever: lever-arm transfer of the linear acceleration
// Four-stage pipeline computing a + alpha x r + w x (w x r) at 2^-12 scale.
// ============================================================================
module ilap_lever
    import ilap_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  item_t                        item,
    input  lane3_t                       arm,
    output logic                         out_valid,
    output side_t                        side_out,
    output logic [2:0][ACC_ROT_W-1:0]    acc_arm
);

    localparam int PROD_W  = SMP_W + LANE_W;
    localparam int CROSS_W = PROD_W + 2;
    localparam int U_W     = PROD_W + 1 - LEV_FRAC;
    localparam int WU_W    = SMP_W + U_W;
    localparam int SUM_W   = WU_W + 2;

    localparam logic signed [CROSS_W-1:0] RND_C = CROSS_W'(1 << (LEV_FRAC - 1));
    localparam logic signed [SUM_W-1:0]   RND_S = SUM_W'(1 << (LEV_FRAC - 1));

    logic signed [SMP_W-1:0]   alpha_s [3];
    logic signed [SMP_W-1:0]   rate_s  [3];
    logic signed [LANE_W-1:0]  arm_s   [3];
    logic signed [SMP_W-1:0]   rate2_s [3];
    logic signed [SMP_W-1:0]   acc3_s  [3];

    // Stage 1: products of both cross products with r.
    logic signed [PROD_W-1:0]  ar_p_reg [3];
    logic signed [PROD_W-1:0]  ar_n_reg [3];
    logic signed [PROD_W-1:0]  wr_p_reg [3];
    logic signed [PROD_W-1:0]  wr_n_reg [3];
    // Stage 2: alpha x r, and w x r rounded to 2^-12.
    logic signed [CROSS_W-1:0] ar2_reg  [3];
    logic signed [U_W-1:0]     u_reg    [3];
    logic signed [CROSS_W-1:0] wr_rnd   [3];
    // Stage 3: products of w x u.
    logic signed [WU_W-1:0]    wu_p_reg [3];
    logic signed [WU_W-1:0]    wu_n_reg [3];
    logic signed [CROSS_W-1:0] ar3_reg  [3];
    // Stage 4: exact sum plus rounding offset.
    logic signed [SUM_W-1:0]   acc_ext  [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic signed [SUM_W-1:0]   sum_reg  [3];

    side_t                     side_reg [LEVER_LAT];
    logic [LEVER_LAT-1:0]      valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            alpha_s[i]  = $signed(item.alpha[i]);
            rate_s[i]   = $signed(item.rate[i]);
            arm_s[i]    = $signed(arm[i]);
            rate2_s[i]  = $signed(side_reg[1].rate[i]);
            acc3_s[i]   = $signed(side_reg[2].acc[i]);
            wr_rnd[i]   = wr_p_reg[i] - wr_n_reg[i] + RND_C;
            acc_ext[i]  = SUM_W'(acc3_s[i]) <<< LEV_FRAC;
            sum_next[i] = acc_ext[i] + ar3_reg[i] + wu_p_reg[i] - wu_n_reg[i] + RND_S;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ar_p_reg[i] <= alpha_s[CJ[i]] * arm_s[CK[i]];
                ar_n_reg[i] <= alpha_s[CK[i]] * arm_s[CJ[i]];
                wr_p_reg[i] <= rate_s[CJ[i]] * arm_s[CK[i]];
                wr_n_reg[i] <= rate_s[CK[i]] * arm_s[CJ[i]];

                ar2_reg[i]  <= ar_p_reg[i] - ar_n_reg[i];
                u_reg[i]    <= wr_rnd[i][LEV_FRAC + U_W - 1:LEV_FRAC];

                wu_p_reg[i] <= rate2_s[CJ[i]] * u_reg[CK[i]];
                wu_n_reg[i] <= rate2_s[CK[i]] * u_reg[CJ[i]];
                ar3_reg[i]  <= ar2_reg[i];

                sum_reg[i]  <= sum_next[i];
            end
            side_reg[0] <= '{base: item.base, bias: item.bias,
                             acc: item.acc, rate: item.rate};
            for (int s = 1; s < LEVER_LAT; s++)
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LEVER_LAT-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[LEVER_LAT-1];
    assign side_out  = side_reg[LEVER_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_arm[i] = sum_reg[i][LEV_FRAC + ACC_ROT_W - 1:LEV_FRAC];
        end
    end

endmodule
`default_nettype wire

>>> src/ilap_rot.sv
`default_nettype none
// ============================================================================
// ilap_rot: quaternion rotation of a three-lane vector
// Four-stage pipeline computing v + qw*t + qv x t with t = 2 (qv x v),
// rounding half up at each of the two rescaling points.
// ============================================================================
module ilap_rot
    import ilap_pkg::*;
#(
    parameter int W = SMP_W
)(
    input  logic                          clk,
    input  logic                          en,
    input  logic [QUAT_W-1:0]             quat,
    input  logic [2:0][W-1:0]             v,
    output logic [2:0][W+ROT_GROW-1:0]    o
);

    localparam int P1_W = W + LANE_W;
    localparam int C_W  = P1_W + 2;
    localparam int T_W  = W + 4;
    localparam int P2_W = LANE_W + T_W;
    localparam int O_W  = W + ROT_GROW;
    localparam int S_W  = O_W + ROT_SHIFT;

    localparam logic signed [C_W-1:0] RND_T = C_W'(1 << (ROT_T_SHIFT - 1));
    localparam logic signed [S_W-1:0] RND_O = S_W'(1 << (ROT_SHIFT - 1));

    logic signed [LANE_W-1:0] qw;
    logic signed [LANE_W-1:0] qv     [3];
    logic signed [W-1:0]      v_in   [3];

    logic signed [P1_W-1:0]   c_p_reg [3];
    logic signed [P1_W-1:0]   c_n_reg [3];
    logic signed [W-1:0]      v1_reg  [3];
    logic signed [C_W-1:0]    c_rnd   [3];
    logic signed [T_W-1:0]    t_reg   [3];
    logic signed [W-1:0]      v2_reg  [3];
    logic signed [P2_W-1:0]   d_p_reg [3];
    logic signed [P2_W-1:0]   d_n_reg [3];
    logic signed [P2_W-1:0]   qt_reg  [3];
    logic signed [W-1:0]      v3_reg  [3];
    logic signed [S_W-1:0]    v_ext   [3];
    logic signed [S_W-1:0]    sum_next [3];
    logic signed [S_W-1:0]    sum_reg [3];

    always_comb
    begin
        qw = $signed(quat[LANE_W-1:0]);
        for (int i = 0; i < 3; i++)
        begin
            qv[i]       = $signed(quat[(i + 1) * LANE_W +: LANE_W]);
            v_in[i]     = $signed(v[i]);
            c_rnd[i]    = c_p_reg[i] - c_n_reg[i] + RND_T;
            v_ext[i]    = S_W'(v3_reg[i]) <<< ROT_SHIFT;
            sum_next[i] = v_ext[i] + qt_reg[i] + d_p_reg[i] - d_n_reg[i] + RND_O;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_p_reg[i] <= qv[CJ[i]] * v_in[CK[i]];
                c_n_reg[i] <= qv[CK[i]] * v_in[CJ[i]];
                v1_reg[i]  <= v_in[i];

                t_reg[i]   <= c_rnd[i][ROT_T_SHIFT + T_W - 1:ROT_T_SHIFT];
                v2_reg[i]  <= v1_reg[i];

                d_p_reg[i] <= qv[CJ[i]] * t_reg[CK[i]];
                d_n_reg[i] <= qv[CK[i]] * t_reg[CJ[i]];
                qt_reg[i]  <= qw * t_reg[i];
                v3_reg[i]  <= v2_reg[i];

                sum_reg[i] <= sum_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o[i] = sum_reg[i][S_W-1:ROT_SHIFT];
        end
    end

endmodule
`default_nettype wire

>>> src/imu_lever_arm_predictor.sv
`default_nettype none
// ============================================================================
// imu_lever_arm_predictor: predicted IMU reading from body kinematics
// Top level: configuration registers, intake queue, lever-arm and rotation
// pipelines, bias addition, saturation and the output register.
// ============================================================================
// A sample beat on "sample" carries body acceleration, angular rate and
// angular acceleration in signed Q12.12; each produces exactly one beat on
// "pred" with the predicted accelerometer and gyroscope readings, in order.
// The acceleration is moved to the IMU position (a + alpha x r + w x (w x r)),
// both vectors are rotated by the mounting quaternion, and the biases are added
// when frame_mode bit 0 is set; frame_mode bit 1 selects the base sensor, which
// passes the sample through with only the biases. Each output lane is clamped
// to 24 bits and "saturated" flags any clipping. The block takes one sample
// per clock cycle without gaps while the output is not stalled. A result
// passes from the intake queue through the lever-arm and rotation pipelines
// to the output register. The intake queue holds QUEUE_DEPTH samples, so
// the input keeps accepting beats until it holds that many while the output
// is stalled; the arithmetic pipeline itself advances only when the output
// register is free or being emptied. Registers are written through
// cfg_wr_en/cfg_index/cfg_data and must only be changed while no sample is
// in flight.
// ============================================================================
module imu_lever_arm_predictor
    import ilap_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
    input  logic                    clk,
    input  logic                    rst_n,
    ilap_in_if.sink                 sample,
    ilap_out_if.source              pred,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int ACC_OUT_W  = ACC_ROT_W + ROT_GROW;
    localparam int RATE_OUT_W = RATE_ROT_W + ROT_GROW;
    localparam int BIAS_W     = LANE_W + BIAS_SHIFT;

    // ------------------------------------------------------------------
    // Configuration registers. Bits above a register's width are dropped
    // and writes to indexes past the register map are ignored.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  frame_mode_reg;
    logic [ARM_W-1:0]   lever_arm_reg;
    logic [QUAT_W-1:0]  mount_quat_reg;
    logic [ARM_W-1:0]   accel_bias_reg;
    logic [ARM_W-1:0]   gyro_bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= '0;
            lever_arm_reg  <= '0;
            mount_quat_reg <= QUAT_RESET;
            accel_bias_reg <= '0;
            gyro_bias_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_MODE: frame_mode_reg <= cfg_data[MODE_W-1:0];
                REG_LEVER_ARM:  lever_arm_reg  <= cfg_data[ARM_W-1:0];
                REG_MOUNT_QUAT: mount_quat_reg <= cfg_data[QUAT_W-1:0];
                REG_ACCEL_BIAS: accel_bias_reg <= cfg_data[ARM_W-1:0];
                REG_GYRO_BIAS:  gyro_bias_reg  <= cfg_data[ARM_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. The whole back end moves as one when the output
    // register can take a new beat; the intake queue absorbs the stall.
    // ------------------------------------------------------------------
    logic   pred_valid_reg;
    logic   en;
    logic   pop;
    logic   head_valid;
    item_t  head;

    assign en  = !pred_valid_reg || pred.ready;
    assign pop = en && head_valid;

    ilap_front #(
        .DEPTH      (QUEUE_DEPTH_P)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .frame_mode (frame_mode_reg),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // ------------------------------------------------------------------
    // Lever-arm transfer, then rotation of both vectors in parallel.
    // ------------------------------------------------------------------
    logic                           lev_valid;
    side_t                          lev_side;
    logic [2:0][ACC_ROT_W-1:0]      acc_arm;
    logic [2:0][ACC_OUT_W-1:0]      acc_rot;
    logic [2:0][RATE_OUT_W-1:0]     rate_rot;

    ilap_lever u_lever (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (head_valid),
        .item       (head),
        .arm        (lever_arm_reg),
        .out_valid  (lev_valid),
        .side_out   (lev_side),
        .acc_arm    (acc_arm)
    );

    ilap_rot #(
        .W          (ACC_ROT_W)
    ) u_rot_acc (
        .clk        (clk),
        .en         (en),
        .quat       (mount_quat_reg),
        .v          (acc_arm),
        .o          (acc_rot)
    );

    ilap_rot #(
        .W          (RATE_ROT_W)
    ) u_rot_rate (
        .clk        (clk),
        .en         (en),
        .quat       (mount_quat_reg),
        .v          (lev_side.rate),
        .o          (rate_rot)
    );

    // The raw sample and its class ride alongside the rotation pipelines,
    // so that base-sensor beats can bypass the arithmetic at the end.
    side_t              side_d_reg [ROT_LAT];
    logic [ROT_LAT-1:0] valid_d_reg;
    side_t              side_q;
    logic               valid_q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d_reg[0] <= lev_side;
            for (int s = 1; s < ROT_LAT; s++)
            begin
                side_d_reg[s] <= side_d_reg[s - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= '0;
        end
        else if (en)
        begin
            valid_d_reg <= {valid_d_reg[ROT_LAT-2:0], lev_valid};
        end
    end

    assign side_q  = side_d_reg[ROT_LAT-1];
    assign valid_q = valid_d_reg[ROT_LAT-1];

    // ------------------------------------------------------------------
    // Base-sensor bypass, bias addition and saturation to 24 bits.
    // ------------------------------------------------------------------
    logic signed [ACC_OUT_W-1:0]   acc_pick  [3];
    logic signed [RATE_OUT_W-1:0]  rate_pick [3];
    logic signed [BIAS_W-1:0]      abias     [3];
    logic signed [BIAS_W-1:0]      gbias     [3];
    logic signed [ACC_OUT_W:0]     acc_sum   [3];
    logic signed [RATE_OUT_W:0]    rate_sum  [3];
    logic [2:0]                    acc_hi, acc_lo, rate_hi, rate_lo;
    vec3_t                         acc_res;
    vec3_t                         rate_res;
    logic                          sat_res;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_pick[i]  = side_q.base ? ACC_OUT_W'($signed(side_q.acc[i]))
                                       : $signed(acc_rot[i]);
            rate_pick[i] = side_q.base ? RATE_OUT_W'($signed(side_q.rate[i]))
                                       : $signed(rate_rot[i]);
            abias[i]     = side_q.bias
                         ? $signed({accel_bias_reg[i * LANE_W +: LANE_W], {BIAS_SHIFT{1'b0}}})
                         : '0;
            gbias[i]     = side_q.bias
                         ? $signed({gyro_bias_reg[i * LANE_W +: LANE_W], {BIAS_SHIFT{1'b0}}})
                         : '0;
            acc_sum[i]   = acc_pick[i] + abias[i];
            rate_sum[i]  = rate_pick[i] + gbias[i];

            acc_hi[i]    = acc_sum[i] > (ACC_OUT_W + 1)'(SMP_MAX);
            acc_lo[i]    = acc_sum[i] < (ACC_OUT_W + 1)'(SMP_MIN);
            rate_hi[i]   = rate_sum[i] > (RATE_OUT_W + 1)'(SMP_MAX);
            rate_lo[i]   = rate_sum[i] < (RATE_OUT_W + 1)'(SMP_MIN);

            acc_res[i]   = acc_hi[i] ? SMP_MAX
                         : acc_lo[i] ? SMP_MIN
                         : acc_sum[i][SMP_W-1:0];
            rate_res[i]  = rate_hi[i] ? SMP_MAX
                         : rate_lo[i] ? SMP_MIN
                         : rate_sum[i][SMP_W-1:0];
        end
        sat_res = |{acc_hi, acc_lo, rate_hi, rate_lo};
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    vec3_t  pred_acc_reg;
    vec3_t  pred_rate_reg;
    logic   saturated_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pred_acc_reg  <= acc_res;
            pred_rate_reg <= rate_res;
            saturated_reg <= sat_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pred_valid_reg <= valid_q;
        end
    end

    assign pred.valid       = pred_valid_reg;
    assign pred.pred_acc_x  = pred_acc_reg[0];
    assign pred.pred_acc_y  = pred_acc_reg[1];
    assign pred.pred_acc_z  = pred_acc_reg[2];
    assign pred.pred_rate_x = pred_rate_reg[0];
    assign pred.pred_rate_y = pred_rate_reg[1];
    assign pred.pred_rate_z = pred_rate_reg[2];
    assign pred.saturated   = saturated_reg;

`ifndef SYNTHESIS
    // No sample leaves the queue while the output beat is held back.
    a_no_pop_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pred.valid && !pred.ready) |-> !pop
    ) else $error("queue popped while the output register was stalled");

    // A saturated beat has at least one lane pinned to a rail.
    a_sat_on_rail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pred.valid && pred.saturated) |->
            (pred.pred_acc_x == SMP_MAX || pred.pred_acc_x == SMP_MIN ||
             pred.pred_acc_y == SMP_MAX || pred.pred_acc_y == SMP_MIN ||
             pred.pred_acc_z == SMP_MAX || pred.pred_acc_z == SMP_MIN ||
             pred.pred_rate_x == SMP_MAX || pred.pred_rate_x == SMP_MIN ||
             pred.pred_rate_y == SMP_MAX || pred.pred_rate_y == SMP_MIN ||
             pred.pred_rate_z == SMP_MAX || pred.pred_rate_z == SMP_MIN)
    ) else $error("saturation flag set with no lane at a rail");

    // A new output beat only comes from a valid beat at the pipeline end.
    a_valid_origin: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pred.valid) |-> $past(valid_q)
    ) else $error("output beat appeared without a pipeline beat behind it");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the IMU lever-arm predictor
// Drives body kinematic samples through the valid/ready sample channel,
// predicts each IMU reading with an independent fixed-point model of the
// lever-arm move, the quaternion rotation, the biases and the saturation,
// and compares every beat on the pred channel field by field.
// ============================================================================
module testbench;
    import ilap_pkg::*;

    // The directed table and the random phases that follow it.
    localparam int PLAN_ROWS       = 28;
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 90;
    localparam int MAX_GAP         = 4;

    // Time allowed at the end for a stray beat still inside the block, from the
    // intake queue through both arithmetic pipelines to the output register.
    localparam int SETTLE_CYCLES = 1 + LEVER_LAT + ROT_LAT + 1 + QUEUE_DEPTH;

    // Register indexes past the end of the map; writes to them do nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

    localparam logic [SMP_W-1:0] SMP_ONES = '1;

    // One body kinematic sample and one predicted IMU reading.
    typedef struct packed {
        vec3_t acc;
        vec3_t rate;
        vec3_t alpha;
    } kin_t;

    typedef struct packed {
        vec3_t acc;
        vec3_t rate;
        logic  sat;
    } reading_t;

    // A row of the directed table is either a register write or a sample.
    typedef enum logic {
        STEP_WRITE,
        STEP_BEAT
    } step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   known;
        kin_t                   beat;
        reading_t               want;
    } step_t;

    typedef longint lvec_t [3];

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ilap_in_if  sample_if ();
    ilap_out_if pred_if ();

    imu_lever_arm_predictor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .pred      (pred_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the configuration registers, updated on every write.
    logic [MODE_W-1:0]  mode_q;
    logic [ARM_W-1:0]   arm_q;
    logic [QUAT_W-1:0]  quat_q;
    logic [ARM_W-1:0]   abias_q;
    logic [ARM_W-1:0]   gbias_q;

    // Readings predicted for accepted samples, oldest first.
    reading_t pending_readings [$];
    int       fail_count;

    // While calm is set neither side inserts idle cycles, so some phases run
    // back to back. offering and taking mirror what was last driven on the
    // two valid/ready lines so that each line is assigned once per edge.
    bit calm;
    bit offering;
    bit taking;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Round half up: add half an LSB, then an arithmetic (floor) shift.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // One signed 16-bit lane of a packed register.
    function automatic longint lane16(input logic [63:0] word, input int i);
        return longint'($signed(word[16 * i +: 16]));
    endfunction

    function automatic void cross3(input lvec_t a, input lvec_t b, output lvec_t o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // v' = v + qw t + qv x t with t = 2 (qv x v); the quaternion is used as
    // written, so a non-unit quaternion scales the vector.
    function automatic void rotate_by_mount(input lvec_t v, output lvec_t o);
        lvec_t  qv;
        lvec_t  c;
        lvec_t  t;
        lvec_t  d;
        longint qw;
        qw = lane16(quat_q, 0);
        for (int i = 0; i < 3; i++)
            qv[i] = lane16(quat_q, i + 1);
        cross3(qv, v, c);
        for (int i = 0; i < 3; i++)
            t[i] = round_shift(c[i], ROT_T_SHIFT);
        cross3(qv, t, d);
        for (int i = 0; i < 3; i++)
            o[i] = round_shift(v[i] * (longint'(1) <<< ROT_SHIFT) + qw * t[i] + d[i],
                               ROT_SHIFT);
    endfunction

    function automatic logic [SMP_W-1:0] clamp_sample(input longint v, inout logic clip);
        if (v > longint'(SMP_MAX))
        begin
            clip = 1'b1;
            return SMP_MAX;
        end
        if (v < longint'(SMP_MIN))
        begin
            clip = 1'b1;
            return SMP_MIN;
        end
        return v[SMP_W-1:0];
    endfunction

    function automatic reading_t predict_reading(input kin_t k);
        lvec_t    acc;
        lvec_t    rate;
        lvec_t    alpha;
        lvec_t    r;
        lvec_t    ar;
        lvec_t    wr;
        lvec_t    u;
        lvec_t    wu;
        lvec_t    lifted;
        lvec_t    va;
        lvec_t    vr;
        longint   ba;
        longint   bg;
        logic     clip;
        reading_t p;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc[i]   = longint'($signed(k.acc[i]));
            rate[i]  = longint'($signed(k.rate[i]));
            alpha[i] = longint'($signed(k.alpha[i]));
        end
        if (mode_q[MODE_BASE_BIT])
        begin
            // The base sensor sees the body sample as it is.
            va = acc;
            vr = rate;
        end
        else
        begin
            // Move the acceleration to the IMU: a + alpha x r + w x (w x r),
            // with w x r rounded back to Q12.12 before the second product.
            for (int i = 0; i < 3; i++)
                r[i] = lane16(arm_q, i);
            cross3(alpha, r, ar);
            cross3(rate, r, wr);
            for (int i = 0; i < 3; i++)
                u[i] = round_shift(wr[i], LEV_FRAC);
            cross3(rate, u, wu);
            for (int i = 0; i < 3; i++)
                lifted[i] = round_shift(acc[i] * (longint'(1) <<< LEV_FRAC) + ar[i] + wu[i],
                                        LEV_FRAC);
            rotate_by_mount(lifted, va);
            rotate_by_mount(rate, vr);
        end
        for (int i = 0; i < 3; i++)
        begin
            ba = mode_q[MODE_BIAS_BIT] ? lane16(abias_q, i) * (longint'(1) <<< BIAS_SHIFT) : 0;
            bg = mode_q[MODE_BIAS_BIT] ? lane16(gbias_q, i) * (longint'(1) <<< BIAS_SHIFT) : 0;
            p.acc[i]  = clamp_sample(va[i] + ba, clip);
            p.rate[i] = clamp_sample(vr[i] + bg, clip);
        end
        p.sat = clip;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Builders for the directed table
    // ------------------------------------------------------------------------

    function automatic vec3_t v3(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
                                 input logic [SMP_W-1:0] z);
        vec3_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        return v;
    endfunction

    function automatic kin_t kin(input vec3_t a, input vec3_t w, input vec3_t al);
        kin_t k;
        k.acc   = a;
        k.rate  = w;
        k.alpha = al;
        return k;
    endfunction

    function automatic reading_t reading(input vec3_t a, input vec3_t w, input logic sat);
        reading_t p;
        p.acc  = a;
        p.rate = w;
        p.sat  = sat;
        return p;
    endfunction

    function automatic step_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s       = '0;
        s.kind  = STEP_WRITE;
        s.idx   = idx;
        s.data  = data;
        return s;
    endfunction

    // A sample whose reading comes from the predictor.
    function automatic step_t beat_row(input kin_t k);
        step_t s;
        s       = '0;
        s.kind  = STEP_BEAT;
        s.beat  = k;
        return s;
    endfunction

    // A sample whose reading is written out in the table.
    function automatic step_t known_row(input kin_t k, input reading_t p);
        step_t s;
        s       = beat_row(k);
        s.known = 1'b1;
        s.want  = p;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------

    // Mostly full-range or realistic magnitudes, with the extremes mixed in.
    function automatic logic [SMP_W-1:0] draw_value();
        case ($urandom_range(0, 5))
            0, 1: return SMP_W'($urandom);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    3: return SMP_W'(1);
                    default: return SMP_ONES;
                endcase
            end
            3: return SMP_W'(int'($urandom_range(0, 8192)) - 4096);
            default: return SMP_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic logic [LANE_W-1:0] draw_lane();
        case ($urandom_range(0, 3))
            0: return LANE_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return LANE_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // A register write pulses the enable for a single cycle and returns with
    // it low, so back-to-back writes never assign it twice at one edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_MODE: mode_q  = data[MODE_W-1:0];
            REG_LEVER_ARM:  arm_q   = data[ARM_W-1:0];
            REG_MOUNT_QUAT: quat_q  = data[QUAT_W-1:0];
            REG_ACCEL_BIAS: abias_q = data[ARM_W-1:0];
            REG_GYRO_BIAS:  gbias_q = data[ARM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one sample after a random gap and wait for the handshake. The
    // reading is predicted at acceptance, with the configuration in force.
    task automatic send_beat(input kin_t k, input logic known, input reading_t typed);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            if (offering)
            begin
                sample_if.valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        sample_if.acc_x     <= k.acc[0];
        sample_if.acc_y     <= k.acc[1];
        sample_if.acc_z     <= k.acc[2];
        sample_if.rate_x    <= k.rate[0];
        sample_if.rate_y    <= k.rate[1];
        sample_if.rate_z    <= k.rate[2];
        sample_if.ang_acc_x <= k.alpha[0];
        sample_if.ang_acc_y <= k.alpha[1];
        sample_if.ang_acc_z <= k.alpha[2];
        if (!offering)
        begin
            sample_if.valid <= 1'b1;
            offering = 1'b1;
        end
        do
            @(posedge clk);
        while (sample_if.ready !== 1'b1);
        if (known)
            pending_readings.push_back(typed);
        else
            pending_readings.push_back(predict_reading(k));
    endtask

    // Stop offering and wait until every outstanding reading has come back,
    // which leaves the block empty and safe to reconfigure.
    task automatic drain_readings();
        if (offering)
        begin
            sample_if.valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Reading checker: random back-pressure, then compare each beat with the
    // oldest prediction.
    // ------------------------------------------------------------------------
    initial
    begin
        int       stall;
        reading_t got;
        reading_t want;
        pred_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                if (taking)
                begin
                    pred_if.ready <= 1'b0;
                    taking = 1'b0;
                end
                repeat (stall) @(posedge clk);
            end
            if (!taking)
            begin
                pred_if.ready <= 1'b1;
                taking = 1'b1;
            end
            do
                @(posedge clk);
            while (pred_if.valid !== 1'b1);
            got = reading(v3(pred_if.pred_acc_x, pred_if.pred_acc_y, pred_if.pred_acc_z),
                          v3(pred_if.pred_rate_x, pred_if.pred_rate_y, pred_if.pred_rate_z),
                          pred_if.saturated);
            if (pending_readings.size() == 0)
            begin
                $display("%0t: reading beat with no sample outstanding: %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got.acc[i] !== want.acc[i])
                    begin
                        $display("%0t: pred_acc[%0d] expected %h, actual %h",
                                 $time, i, want.acc[i], got.acc[i]);
                        fail_count++;
                    end
                    if (got.rate[i] !== want.rate[i])
                    begin
                        $display("%0t: pred_rate[%0d] expected %h, actual %h",
                                 $time, i, want.rate[i], got.rate[i]);
                        fail_count++;
                    end
                end
                if (got.sat !== want.sat)
                begin
                    $display("%0t: saturated expected %b, actual %b", $time, want.sat, got.sat);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        step_t                  plan [PLAN_ROWS];
        kin_t                   k;
        logic [CFG_DATA_W-1:0]  data_w;
        logic [MODE_W-1:0]      mode_n;
        logic [ARM_W-1:0]       arm_n;
        logic [QUAT_W-1:0]      quat_n;
        logic [ARM_W-1:0]       abias_n;
        logic [ARM_W-1:0]       gbias_n;
        real                    qr [4];
        real                    norm;

        // Every input is known from time zero while reset is held.
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        sample_if.valid     <= 1'b0;
        sample_if.acc_x     <= '0;
        sample_if.acc_y     <= '0;
        sample_if.acc_z     <= '0;
        sample_if.rate_x    <= '0;
        sample_if.rate_y    <= '0;
        sample_if.rate_z    <= '0;
        sample_if.ang_acc_x <= '0;
        sample_if.ang_acc_y <= '0;
        sample_if.ang_acc_z <= '0;
        mode_q     = '0;
        arm_q      = '0;
        quat_q     = QUAT_RESET;
        abias_q    = '0;
        gbias_q    = '0;
        fail_count = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Out of reset the lever arm is zero and the
        // quaternion is the identity, so a sample comes back unchanged. In
        // base mode with biases the readings are the sample plus 16 times
        // each bias lane, which makes the clipping edges easy to write out.
        plan = '{
            // Reset configuration: pass-through at the field extremes.
            known_row(kin(v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0)),
                      reading(v3(0, 0, 0), v3(0, 0, 0), 1'b0)),
            known_row(kin(v3(SMP_MAX, SMP_MIN, 1), v3(SMP_MIN, SMP_MAX, SMP_ONES),
                          v3(SMP_MAX, SMP_MAX, SMP_MIN)),
                      reading(v3(SMP_MAX, SMP_MIN, 1), v3(SMP_MIN, SMP_MAX, SMP_ONES), 1'b0)),
            known_row(kin(v3(SMP_MIN, SMP_MAX, 0), v3(1, SMP_ONES, SMP_MAX),
                          v3(SMP_MIN, SMP_MIN, SMP_MAX)),
                      reading(v3(SMP_MIN, SMP_MAX, 0), v3(1, SMP_ONES, SMP_MAX), 1'b0)),
            // Writes past the register map must leave everything as it was.
            write_row(REG_SPARE_A, '1),
            write_row(REG_SPARE_B, '1),
            write_row(REG_SPARE_C, '1),
            known_row(kin(v3(24'h123456, 24'hABCDEF, 24'h000800),
                          v3(24'hFFF000, 24'h001000, 24'h7FF000),
                          v3(24'h555555, 24'hAAAAAA, 24'h0F0F0F)),
                      reading(v3(24'h123456, 24'hABCDEF, 24'h000800),
                              v3(24'hFFF000, 24'h001000, 24'h7FF000), 1'b0)),
            // Base sensor without biases; junk above each register's width.
            // The extreme lever arm and quaternion must have no effect.
            write_row(REG_FRAME_MODE, 64'hFFFF_FFFF_FFFF_FFFE),
            write_row(REG_ACCEL_BIAS, 64'hDEAD_0001_8000_7FFF),
            write_row(REG_GYRO_BIAS,  64'hBEEF_FFFF_7FFF_8000),
            write_row(REG_LEVER_ARM,  64'hFFFF_7FFF_8000_7FFF),
            write_row(REG_MOUNT_QUAT, 64'h8000_7FFF_8000_7FFF),
            known_row(kin(v3(SMP_MAX, SMP_MIN, SMP_ONES), v3(SMP_MIN, SMP_MAX, 1),
                          v3(SMP_MAX, SMP_MIN, SMP_MAX)),
                      reading(v3(SMP_MAX, SMP_MIN, SMP_ONES), v3(SMP_MIN, SMP_MAX, 1), 1'b0)),
            // Base sensor with biases: accel bias (+max, -max, +1 LSB), gyro
            // bias (-max, +max, -1 LSB), each scaled by 16.
            write_row(REG_FRAME_MODE, 64'h0000_0000_0000_0003),
            known_row(kin(v3(SMP_MAX, SMP_MIN, 0), v3(SMP_MIN, SMP_MAX, 24'h000010),
                          v3(0, 0, 0)),
                      reading(v3(SMP_MAX, SMP_MIN, 24'h000010), v3(SMP_MIN, SMP_MAX, 0), 1'b1)),
            known_row(kin(v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0)),
                      reading(v3(24'h07FFF0, 24'hF80000, 24'h000010),
                              v3(24'hF80000, 24'h07FFF0, 24'hFFFFF0), 1'b0)),
            // Sums that land exactly on the limits do not clip...
            known_row(kin(v3(24'h78000F, 24'h880000, 0), v3(24'h880000, 24'h78000F, 0),
                          v3(0, 0, 0)),
                      reading(v3(SMP_MAX, SMP_MIN, 24'h000010),
                              v3(SMP_MIN, SMP_MAX, 24'hFFFFF0), 1'b0)),
            // ...while one LSB more on a single lane does.
            known_row(kin(v3(24'h780010, 0, 0), v3(0, 0, 0), v3(0, 0, 0)),
                      reading(v3(SMP_MAX, 24'hF80000, 24'h000010),
                              v3(24'hF80000, 24'h07FFF0, 24'hFFFFF0), 1'b1)),
            // Full path with biases, extreme lever arm and a non-unit
            // quaternion; these rows go through the predictor.
            write_row(REG_FRAME_MODE, 64'h0000_0000_0000_0001),
            beat_row(kin(v3(24'h001000, 24'hFFF000, 24'h000800),
                         v3(24'h000400, 24'hFFFC00, 24'h000200),
                         v3(24'h000100, 24'h000080, 24'hFFFF00))),
            beat_row(kin(v3(SMP_MAX, SMP_MAX, SMP_MAX), v3(SMP_MIN, SMP_MIN, SMP_MIN),
                         v3(SMP_MIN, SMP_MAX, SMP_MIN))),
            // A quarter turn about z and a modest lever arm, no biases.
            write_row(REG_MOUNT_QUAT, 64'h2D41_0000_0000_2D41),
            write_row(REG_LEVER_ARM,  64'h7777_0800_F800_1000),
            write_row(REG_FRAME_MODE, 64'h0000_0000_0000_0000),
            beat_row(kin(v3(24'h002000, 24'h000000, 24'h009CCD),
                         v3(24'h000800, 24'hFFF800, 24'h001000),
                         v3(24'h000400, 24'h000000, 24'hFFFC00))),
            beat_row(kin(v3(SMP_MIN, 0, SMP_MAX), v3(SMP_MAX, SMP_MAX, SMP_MAX),
                         v3(SMP_MAX, SMP_MIN, 0))),
            // An all-zero quaternion is applied as written.
            write_row(REG_MOUNT_QUAT, 64'h0000_0000_0000_0000),
            beat_row(kin(v3(1, SMP_ONES, 0), v3(24'h000100, 24'h000200, 24'h000300),
                         v3(24'h000010, 24'h000020, 24'h000030)))
        };

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == STEP_WRITE)
            begin
                drain_readings();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_beat(plan[i].beat, plan[i].known, plan[i].want);
            end
        end

        // Random part: each phase drains the block, writes all five registers
        // and streams random samples. Phases 0 and 1 pin the registers to their
        // extremes, phase 2 clears them; every fourth phase runs without idles.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_readings();
            calm = (ph % 4 == 3);
            case (ph)
                0:
                begin
                    mode_n  = 2'b11;
                    arm_n   = {3{16'h7FFF}};
                    quat_n  = {4{16'h7FFF}};
                    abias_n = {3{16'h7FFF}};
                    gbias_n = {3{16'h8000}};
                end
                1:
                begin
                    mode_n  = 2'b01;
                    arm_n   = {3{16'h8000}};
                    quat_n  = {4{16'h8000}};
                    abias_n = {3{16'h8000}};
                    gbias_n = {3{16'h7FFF}};
                end
                2:
                begin
                    mode_n  = 2'b00;
                    arm_n   = '0;
                    quat_n  = '0;
                    abias_n = '0;
                    gbias_n = '0;
                end
                default:
                begin
                    mode_n  = MODE_W'($urandom_range(0, 3));
                    arm_n   = {draw_lane(), draw_lane(), draw_lane()};
                    abias_n = {draw_lane(), draw_lane(), draw_lane()};
                    gbias_n = {draw_lane(), draw_lane(), draw_lane()};
                    if ($urandom_range(0, 3) != 0)
                    begin
                        // A random mounting of unit length, scaled to Q1.14.
                        norm = 0.0;
                        for (int j = 0; j < 4; j++)
                        begin
                            qr[j] = real'(int'($urandom_range(0, 32768)) - 16384);
                            norm  = norm + qr[j] * qr[j];
                        end
                        norm = $sqrt(norm);
                        if (norm < 1.0)
                            quat_n = QUAT_RESET;
                        else
                            for (int j = 0; j < 4; j++)
                                quat_n[LANE_W * j +: LANE_W] =
                                    LANE_W'($rtoi(qr[j] * 16384.0 / norm));
                    end
                    else
                    begin
                        quat_n = {draw_lane(), draw_lane(), draw_lane(), draw_lane()};
                    end
                end
            endcase

            // The bits above each register's width carry junk.
            data_w = {$urandom, $urandom};
            data_w[MODE_W-1:0] = mode_n;
            write_reg(REG_FRAME_MODE, data_w);
            data_w = {$urandom, $urandom};
            data_w[ARM_W-1:0] = arm_n;
            write_reg(REG_LEVER_ARM, data_w);
            write_reg(REG_MOUNT_QUAT, quat_n);
            data_w = {$urandom, $urandom};
            data_w[ARM_W-1:0] = abias_n;
            write_reg(REG_ACCEL_BIAS, data_w);
            data_w = {$urandom, $urandom};
            data_w[ARM_W-1:0] = gbias_n;
            write_reg(REG_GYRO_BIAS, data_w);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE_A + CFG_IDX_W'($urandom_range(0, 2)),
                          {$urandom, $urandom});

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    k.acc[i]   = draw_value();
                    k.rate[i]  = draw_value();
                    k.alpha[i] = draw_value();
                end
                send_beat(k, 1'b0, '0);
            end
        end

        // Let the last readings arrive, then give any stray beat time to show.
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
